// File: hdl/ttb_pkg.sv
// ----------------------------------------------------------------------------
// ttb_pkg
// Shared widths and constants for the triangle tangent/binormal block.
// ----------------------------------------------------------------------------
package ttb_pkg;

  localparam int POS_WIDTH_DEF = 32;
  localparam int UV_WIDTH_DEF  = 24;

  localparam int NORM_BITS = 30;                       // normalized magnitude bits
  localparam int OUT_W     = 16;                       // Q1.14 output word
  localparam int OUT_FRAC  = 14;
  localparam logic [OUT_W-1:0] OUT_ONE = OUT_W'(1) << OUT_FRAC;

  localparam int SUM_W = 2 * NORM_BITS + 2;            // sum of three squares
  localparam int LEN_W = SUM_W / 2;                    // integer square root
  localparam int QUO_W = OUT_W;                        // quotient bits
  localparam int NUM_W = NORM_BITS + OUT_FRAC + 1;     // mag*one + len/2

endpackage

// File: hdl/ttb_mul.sv
// ----------------------------------------------------------------------------
// ttb_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module ttb_mul #(
  parameter int AW = 31,
  parameter int BW = 33
) (
  input  logic                  clk_i,
  input  logic signed [AW-1:0]  a_i,
  input  logic signed [BW-1:0]  b_i,
  output logic signed [AW+BW-1:0] p_o
);

  logic signed [AW+BW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= (AW+BW)'(a_i) * (AW+BW)'(b_i);
  end

  assign p_o = p_q;

endmodule

// File: hdl/ttb_isqrt.sv
// ----------------------------------------------------------------------------
// ttb_isqrt
// Floor integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module ttb_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ttb_pkg::SUM_W-1:0]  n_i,
  output logic                       done_o,
  output logic [ttb_pkg::LEN_W-1:0]  root_o
);
  import ttb_pkg::*;

  localparam int STEPS = SUM_W / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [SUM_W-1:0] n_q, res_q, bit_q, trial;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;

  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNT_W'(STEPS);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= n_i;
      res_q <= '0;
      bit_q <= SUM_W'(1) << (SUM_W - 2);
    end else if (cnt_q != '0) begin
      if (n_q >= trial) begin
        n_q   <= n_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[LEN_W-1:0];

endmodule

// File: hdl/ttb_div.sv
// ----------------------------------------------------------------------------
// ttb_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ttb_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ttb_pkg::NUM_W-1:0]  num_i,
  input  logic [ttb_pkg::LEN_W-1:0]  den_i,
  output logic                       done_o,
  output logic [ttb_pkg::QUO_W-1:0]  quo_o
);
  import ttb_pkg::*;

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [LEN_W-1:0] rem_q, den_q;
  logic [QUO_W-1:0] sh_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [LEN_W:0]   trial;
  logic             qbit;

  // caller guarantees the quotient fits, so the high part starts below den
  assign trial = {rem_q, sh_q[QUO_W-1]};
  assign qbit  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNT_W'(QUO_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= LEN_W'(num_i[NUM_W-1:QUO_W]);
      sh_q  <= num_i[QUO_W-1:0];
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      rem_q <= qbit ? LEN_W'(trial - {1'b0, den_q}) : trial[LEN_W-1:0];
      sh_q  <= {sh_q[QUO_W-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quo_o  = sh_q;

endmodule

// File: hdl/triangle_tangent_binormal.sv
// ----------------------------------------------------------------------------
// triangle_tangent_binormal
// Tangent and binormal per triangle from vertex positions and UVs.
// ----------------------------------------------------------------------------
// First and second vertex of a triangle: accepted and stored, no result.
// Third vertex: multiply steps for det and both cross products, then per
//   vector a check, normalizing shifts, three squares, a root and three divides;
//   a degenerate triangle ends early; input stalled until the result register takes the result.
// One result register; a waiting result does not block the first two vertices.
// rst_ni clears the vertex phase, the sequencer and the output valid.
module triangle_tangent_binormal #(
  parameter int POS_WIDTH = ttb_pkg::POS_WIDTH_DEF,
  parameter int UV_WIDTH  = ttb_pkg::UV_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [POS_WIDTH-1:0]   pos_x_i,
  input  logic signed [POS_WIDTH-1:0]   pos_y_i,
  input  logic signed [POS_WIDTH-1:0]   pos_z_i,
  input  logic signed [UV_WIDTH-1:0]    tex_u_i,
  input  logic signed [UV_WIDTH-1:0]    tex_v_i,
  input  logic                          mesh_start_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [ttb_pkg::OUT_W-1:0] tangent_x_o,
  output logic signed [ttb_pkg::OUT_W-1:0] tangent_y_o,
  output logic signed [ttb_pkg::OUT_W-1:0] tangent_z_o,
  output logic signed [ttb_pkg::OUT_W-1:0] binormal_x_o,
  output logic signed [ttb_pkg::OUT_W-1:0] binormal_y_o,
  output logic signed [ttb_pkg::OUT_W-1:0] binormal_z_o,
  output logic                          degenerate_o
);
  import ttb_pkg::*;

  localparam int EW = POS_WIDTH + 1;
  localparam int DW = UV_WIDTH + 1;
  localparam int XW = (EW > DW) ? EW : DW;
  localparam int CW = XW + DW + 1;
  localparam int AW = (DW > NORM_BITS + 1) ? DW : NORM_BITS + 1;
  localparam int BW = (XW > NORM_BITS + 1) ? XW : NORM_BITS + 1;
  localparam int PW = AW + BW;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL    = 4'd1;
  localparam logic [3:0] S_NCHK   = 4'd2;
  localparam logic [3:0] S_SHIFT  = 4'd3;
  localparam logic [3:0] S_SQ     = 4'd4;
  localparam logic [3:0] S_SQRT   = 4'd5;
  localparam logic [3:0] S_DSTART = 4'd6;
  localparam logic [3:0] S_DIV    = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  localparam logic [3:0] LAST_STEP = 4'd13;

  logic [3:0] state_q;
  logic [1:0] phase_q;
  logic [3:0] step_q;
  logic       half_q;       // 0: operands issued, 1: product ready
  logic [1:0] idx_q;
  logic       vec_q;
  logic       flip_q;
  logic       deg_q;

  logic signed [POS_WIDTH-1:0] hp_q [2][3];
  logic signed [UV_WIDTH-1:0]  ht_q [2][2];
  logic signed [EW-1:0] e1_q [3];
  logic signed [EW-1:0] e2_q [3];
  logic signed [DW-1:0] du1_q, dv1_q, du2_q, dv2_q;
  logic signed [CW-1:0] acc_q;
  logic signed [CW-1:0] cross_q [7];
  logic [CW-1:0]        mag_q [3];
  logic [2:0]           neg_q;
  logic [SUM_W-1:0]     sum_q;
  logic [LEN_W-1:0]     len_q;
  logic [OUT_W-1:0]     res_q [6];

  logic                 out_valid_q, deg_out_q;
  logic [OUT_W-1:0]     out_q [6];

  logic accept, third, out_free;
  logic [1:0] ph_eff;
  logic signed [POS_WIDTH-1:0] pin [3];

  assign accept   = in_valid_i && !in_stall_o;
  assign ph_eff   = mesh_start_i ? 2'd0 : phase_q;
  assign third    = ph_eff[1];                 // phase three acts as phase two
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign pin[0] = pos_x_i;
  assign pin[1] = pos_y_i;
  assign pin[2] = pos_z_i;

  // shared multiplier and its operand selection
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] mul_p;
  logic [2:0] pair;
  logic       odd;
  logic [1:0] tix, bix;

  assign pair = step_q[3:1];
  assign odd  = step_q[0];
  assign tix  = 2'(pair - 3'd1);
  assign bix  = 2'(pair - 3'd4);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == S_SQ) begin
      mul_a = $signed(AW'(mag_q[idx_q][NORM_BITS-1:0]));
      mul_b = $signed(BW'(mag_q[idx_q][NORM_BITS-1:0]));
    end else begin
      case (pair)
        3'd0: begin
          mul_a = odd ? AW'(dv1_q) : AW'(du1_q);
          mul_b = odd ? BW'(du2_q) : BW'(dv2_q);
        end
        3'd1, 3'd2, 3'd3: begin
          mul_a = odd ? AW'(dv1_q) : AW'(dv2_q);
          mul_b = odd ? BW'(e2_q[tix]) : BW'(e1_q[tix]);
        end
        3'd4, 3'd5, 3'd6: begin
          mul_a = odd ? AW'(du2_q) : AW'(du1_q);
          mul_b = odd ? BW'(e1_q[bix]) : BW'(e2_q[bix]);
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  ttb_mul #(.AW(AW), .BW(BW)) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // root and divide units
  logic             sq_start, sq_done;
  logic [LEN_W-1:0] sq_root;
  logic             dv_start, dv_done;
  logic [NUM_W-1:0] dv_num;
  logic [QUO_W-1:0] dv_quo;

  assign sq_start = (state_q == S_SQ) && half_q && (idx_q == 2'd2);
  assign dv_start = (state_q == S_DSTART);
  assign dv_num   = NUM_W'({mag_q[idx_q][NORM_BITS-1:0], {OUT_FRAC{1'b0}}})
                  + NUM_W'(len_q >> 1);

  ttb_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .n_i     (sum_q + SUM_W'(mul_p[2*NORM_BITS-1:0])),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  ttb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .num_i   (dv_num),
    .den_i   (len_q),
    .done_o  (dv_done),
    .quo_o   (dv_quo)
  );

  // vector selection for normalization
  logic signed [CW-1:0] vsrc [3];
  logic [CW-1:0]        vmag [3];
  logic [2:0]           vneg;
  logic [CW-1:0]        mag_or;
  logic [OUT_W-1:0]     q_cap, q_out;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vsrc[i] = vec_q ? cross_q[4+i] : cross_q[1+i];
      vneg[i] = vsrc[i][CW-1];
      vmag[i] = vneg[i] ? CW'(-vsrc[i]) : CW'(vsrc[i]);
    end
  end

  assign mag_or = mag_q[0] | mag_q[1] | mag_q[2];
  assign q_cap  = (dv_quo > OUT_ONE) ? OUT_ONE : dv_quo;
  assign q_out  = (neg_q[idx_q] ^ flip_q) ? OUT_W'(-q_cap) : q_cap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= 2'd0;
      step_q      <= '0;
      half_q      <= 1'b0;
      idx_q       <= '0;
      vec_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_OUT) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (third) begin
              phase_q <= 2'd0;
              step_q  <= '0;
              half_q  <= 1'b0;
              state_q <= S_MUL;
            end else begin
              phase_q <= ph_eff + 2'd1;
            end
          end
        end
        S_MUL: begin
          half_q <= !half_q;
          if (half_q) begin
            if (step_q == LAST_STEP) begin
              vec_q   <= 1'b0;
              state_q <= (cross_q[0] == '0) ? S_OUT : S_NCHK;
            end else begin
              step_q <= step_q + 4'd1;
            end
          end
        end
        S_NCHK: begin
          state_q <= ((vmag[0] | vmag[1] | vmag[2]) == '0) ? S_OUT : S_SHIFT;
        end
        S_SHIFT: begin
          if (mag_or[CW-1:NORM_BITS] == '0 && mag_or[NORM_BITS-1]) begin
            idx_q   <= '0;
            half_q  <= 1'b0;
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          half_q <= !half_q;
          if (half_q) begin
            if (idx_q == 2'd2) begin
              idx_q   <= '0;
              state_q <= S_SQRT;
            end else begin
              idx_q <= idx_q + 2'd1;
            end
          end
        end
        S_SQRT: begin
          if (sq_done) state_q <= S_DSTART;
        end
        S_DSTART: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (dv_done) begin
            if (idx_q != 2'd2) begin
              idx_q   <= idx_q + 2'd1;
              state_q <= S_DSTART;
            end else if (!vec_q) begin
              vec_q   <= 1'b1;
              state_q <= S_NCHK;
            end else begin
              state_q <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (!third) begin
            for (int i = 0; i < 3; i++) hp_q[ph_eff[0]][i] <= pin[i];
            ht_q[ph_eff[0]][0] <= tex_u_i;
            ht_q[ph_eff[0]][1] <= tex_v_i;
          end else begin
            for (int i = 0; i < 3; i++) begin
              e1_q[i] <= EW'(hp_q[1][i]) - EW'(hp_q[0][i]);
              e2_q[i] <= EW'(pin[i]) - EW'(hp_q[0][i]);
            end
            du1_q <= DW'(ht_q[1][0]) - DW'(ht_q[0][0]);
            dv1_q <= DW'(ht_q[1][1]) - DW'(ht_q[0][1]);
            du2_q <= DW'(tex_u_i) - DW'(ht_q[0][0]);
            dv2_q <= DW'(tex_v_i) - DW'(ht_q[0][1]);
          end
        end
        deg_q <= 1'b0;
      end
      S_MUL: begin
        if (half_q) begin
          if (!odd) acc_q <= mul_p[CW-1:0];
          else      cross_q[pair] <= acc_q - mul_p[CW-1:0];
          if (step_q == LAST_STEP) begin
            flip_q <= cross_q[0][CW-1];
            deg_q  <= (cross_q[0] == '0);
          end
        end
      end
      S_NCHK: begin
        for (int i = 0; i < 3; i++) mag_q[i] <= vmag[i];
        neg_q <= vneg;
        deg_q <= ((vmag[0] | vmag[1] | vmag[2]) == '0);
      end
      S_SHIFT: begin
        sum_q <= '0;
        if (mag_or[CW-1:NORM_BITS] != '0) begin
          for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
        end else if (!mag_or[NORM_BITS-1]) begin
          for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
        end
      end
      S_SQ: begin
        if (half_q) sum_q <= sum_q + SUM_W'(mul_p[2*NORM_BITS-1:0]);
      end
      S_SQRT: begin
        if (sq_done) len_q <= sq_root;
      end
      S_DIV: begin
        if (dv_done) res_q[vec_q ? 3'd3 + 3'(idx_q) : 3'(idx_q)] <= q_out;
      end
      S_OUT: begin
        if (out_free) begin
          deg_out_q <= deg_q;
          for (int i = 0; i < 6; i++) out_q[i] <= deg_q ? '0 : res_q[i];
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign degenerate_o = deg_out_q;
  assign tangent_x_o  = out_q[0];
  assign tangent_y_o  = out_q[1];
  assign tangent_z_o  = out_q[2];
  assign binormal_x_o = out_q[3];
  assign binormal_y_o = out_q[4];
  assign binormal_z_o = out_q[5];

endmodule

// File: hdl/ttb_checker.sv
// ----------------------------------------------------------------------------
// ttb_checker
// Port-level checks for the tangent/binormal block, bound to the top level.
// ----------------------------------------------------------------------------
module ttb_checker #(
  parameter int POS_WIDTH = ttb_pkg::POS_WIDTH_DEF,
  parameter int UV_WIDTH  = ttb_pkg::UV_WIDTH_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic signed [POS_WIDTH-1:0]   pos_x_i,
  input logic signed [POS_WIDTH-1:0]   pos_y_i,
  input logic signed [POS_WIDTH-1:0]   pos_z_i,
  input logic signed [UV_WIDTH-1:0]    tex_u_i,
  input logic signed [UV_WIDTH-1:0]    tex_v_i,
  input logic                          mesh_start_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [ttb_pkg::OUT_W-1:0] tangent_x_o,
  input logic signed [ttb_pkg::OUT_W-1:0] tangent_y_o,
  input logic signed [ttb_pkg::OUT_W-1:0] tangent_z_o,
  input logic signed [ttb_pkg::OUT_W-1:0] binormal_x_o,
  input logic signed [ttb_pkg::OUT_W-1:0] binormal_y_o,
  input logic signed [ttb_pkg::OUT_W-1:0] binormal_z_o,
  input logic                          degenerate_o
);
  import ttb_pkg::*;

  localparam logic signed [OUT_W-1:0] POS_ONE = $signed(OUT_ONE);
  localparam logic signed [OUT_W-1:0] NEG_ONE = -$signed(OUT_ONE);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |->
      tangent_x_o == '0 && tangent_y_o == '0 && tangent_z_o == '0 &&
      binormal_x_o == '0 && binormal_y_o == '0 && binormal_z_o == '0)
    else $error("degenerate item with nonzero vector");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !degenerate_o |->
      tangent_x_o <= POS_ONE && tangent_x_o >= NEG_ONE &&
      tangent_y_o <= POS_ONE && tangent_y_o >= NEG_ONE &&
      tangent_z_o <= POS_ONE && tangent_z_o >= NEG_ONE &&
      binormal_x_o <= POS_ONE && binormal_x_o >= NEG_ONE &&
      binormal_y_o <= POS_ONE && binormal_y_o >= NEG_ONE &&
      binormal_z_o <= POS_ONE && binormal_z_o >= NEG_ONE)
    else $error("unit vector component out of range");

  a_busy_before_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result item without a busy computation");

endmodule

bind triangle_tangent_binormal ttb_checker #(
  .POS_WIDTH (POS_WIDTH),
  .UV_WIDTH  (UV_WIDTH)
) u_ttb_checker (.*);

// File: tb/triangle_tangent_binormal_tb.sv
// ----------------------------------------------------------------------------
// triangle_tangent_binormal_tb
// Self-checking bench for the triangle tangent/binormal block: a directed
// table of vertices, then random meshes; every result is compared against a
// bit-exact fixed point predictor, under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module triangle_tangent_binormal_tb;
  import ttb_pkg::*;

  localparam int PW = POS_WIDTH_DEF;
  localparam int UW = UV_WIDTH_DEF;
  localparam int RAND_ITEMS = 1730;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 400;
  localparam int HOLD_CYCLES = 3000;

  typedef logic signed [127:0] wide_t;
  typedef logic [2:0][127:0] wvec_t;

  typedef struct packed {
    logic [15:0] tx, ty, tz, bx, by, bz;
    logic        deg;
  } frame_t;

  typedef struct packed {
    logic signed [PW-1:0] px, py, pz;
    logic signed [UW-1:0] tu, tv;
    logic                 ms;
    logic                 chk;
    frame_t               res;
  } vrow_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [PW-1:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic signed [UW-1:0] tex_u_i = '0, tex_v_i = '0;
  logic mesh_start_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b1;
  logic signed [OUT_W-1:0] tangent_x_o, tangent_y_o, tangent_z_o;
  logic signed [OUT_W-1:0] binormal_x_o, binormal_y_o, binormal_z_o;
  logic degenerate_o;

  triangle_tangent_binormal dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic signed [PW-1:0] held_pos [6];
  logic signed [UW-1:0] held_uv [4];
  int unsigned tri_phase;

  frame_t expected_frames [$];
  int errors, frames_seen, vertices_sent, degen_seen;
  int unsigned cycles;
  bit long_hold_done;

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] exp);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, exp, cycles);
    errors++;
  endtask

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // scale vector to a 30-bit peak, then round each component against its length
  function automatic bit to_unit(input wvec_t v, input bit flip, output logic [2:0][15:0] o);
    logic [127:0] mag [3];
    bit neg [3];
    int top;
    logic [63:0] sum, len, q;
    top = 0;
    sum = 0;
    o = '0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i][127];
      mag[i] = neg[i] ? -v[i] : v[i];
      for (int b = 127; b >= 0; b--)
        if (mag[i][b] && b + 1 > top) begin
          top = b + 1;
          break;
        end
    end
    if (top == 0) return 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (top > NORM_BITS) mag[i] = mag[i] >> (top - NORM_BITS);
      else mag[i] = mag[i] << (NORM_BITS - top);
      sum += mag[i][63:0] * mag[i][63:0];
    end
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = (mag[i][63:0] * 64'd16384 + (len >> 1)) / len;
      if (q > 64'd16384) q = 64'd16384;
      if (neg[i] != flip) q = -q;
      o[i] = q[15:0];
    end
    return 1'b1;
  endfunction

  // advance the vertex phase; returns 1 with the frame when a triangle closes
  function automatic bit tangent_frame(input vrow_t r, output frame_t f);
    wide_t e1 [3], e2 [3], p2 [3], h [6];
    wide_t du1, dv1, du2, dv2, det, u0, v0;
    wvec_t tvec, bvec;
    logic [2:0][15:0] tq, bq;
    bit ok;
    f = '0;
    if (r.ms) tri_phase = 0;
    if (tri_phase < 2) begin
      held_pos[tri_phase*3]   = r.px;
      held_pos[tri_phase*3+1] = r.py;
      held_pos[tri_phase*3+2] = r.pz;
      held_uv[tri_phase*2]    = r.tu;
      held_uv[tri_phase*2+1]  = r.tv;
      tri_phase++;
      return 1'b0;
    end
    tri_phase = 0;
    p2[0] = r.px; p2[1] = r.py; p2[2] = r.pz;
    for (int i = 0; i < 6; i++) h[i] = held_pos[i];
    for (int i = 0; i < 3; i++) begin
      e1[i] = h[3+i] - h[i];
      e2[i] = p2[i] - h[i];
    end
    u0 = held_uv[0];
    v0 = held_uv[1];
    du1 = wide_t'(held_uv[2]) - u0;
    dv1 = wide_t'(held_uv[3]) - v0;
    du2 = wide_t'(r.tu) - u0;
    dv2 = wide_t'(r.tv) - v0;
    det = du1 * dv2 - dv1 * du2;
    for (int i = 0; i < 3; i++) begin
      tvec[i] = dv2 * e1[i] - dv1 * e2[i];
      bvec[i] = du1 * e2[i] - du2 * e1[i];
    end
    ok = det != 0;
    if (ok) ok = to_unit(tvec, det[127], tq);
    if (ok) ok = to_unit(bvec, det[127], bq);
    if (ok) begin
      f.tx = tq[0]; f.ty = tq[1]; f.tz = tq[2];
      f.bx = bq[0]; f.by = bq[1]; f.bz = bq[2];
    end
    f.deg = !ok;
    return 1'b1;
  endfunction

  // sender: bursts of items with random gaps
  int burst_left;

  task automatic send_vertex(input vrow_t r);
    frame_t f;
    bit acc;
    in_valid_i = 1'b1;
    pos_x_i = r.px; pos_y_i = r.py; pos_z_i = r.pz;
    tex_u_i = r.tu; tex_v_i = r.tv; mesh_start_i = r.ms;
    acc = 1'b0;
    while (!acc) begin
      @(posedge clk_i);
      acc = in_valid_i && !in_stall_o;
    end
    vertices_sent++;
    if (tangent_frame(r, f)) begin
      if (r.chk && f != r.res) begin
        $display("predictor disagrees with table row at item %0d", vertices_sent);
        errors++;
      end
      expected_frames.push_back(f);
    end
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic [31:0] rand_word(input int w);
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 255) - 128;
      1: v = {1'b0, {31{1'b1}}} >> (32 - w);
      2: v = ~({1'b0, {31{1'b1}}} >> (32 - w));
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic vrow_t rand_vertex(input bit ms);
    vrow_t r;
    r = '0;
    r.px = PW'(rand_word(PW)); r.py = PW'(rand_word(PW)); r.pz = PW'(rand_word(PW));
    r.tu = UW'(rand_word(UW)); r.tv = UW'(rand_word(UW));
    r.ms = ms;
    return r;
  endfunction

  vrow_t table_rows [$];

  task automatic add_row(input logic signed [PW-1:0] x, y, z, input logic signed [UW-1:0] u, v,
                         input bit ms, input bit chk, input frame_t res);
    vrow_t r;
    r.px = x; r.py = y; r.pz = z; r.tu = u; r.tv = v; r.ms = ms; r.chk = chk; r.res = res;
    table_rows.push_back(r);
  endtask

  localparam logic signed [PW-1:0] PMAX = {1'b0, {(PW-1){1'b1}}};
  localparam logic signed [PW-1:0] PMIN = {1'b1, {(PW-1){1'b0}}};
  localparam logic signed [UW-1:0] UMAX = {1'b0, {(UW-1){1'b1}}};
  localparam logic signed [UW-1:0] UMIN = {1'b1, {(UW-1){1'b0}}};
  localparam frame_t NONE = '0;
  localparam frame_t DEGEN = '{default: '0, deg: 1'b1};
  localparam frame_t AXES = '{tx: 16'd16384, ty: 0, tz: 0, bx: 0, by: 16'd16384, bz: 0, deg: 0};
  localparam frame_t MIRROR = '{tx: 16'd16384, ty: 0, tz: 0, bx: 0, by: -16'sd16384, bz: 0,
                                deg: 0};

  initial begin
    vrow_t r;
    int tri_left;
    // right triangle, axis-aligned UVs
    add_row(0, 0, 0, 0, 0, 1, 0, NONE);
    add_row(65536, 0, 0, 65536, 0, 0, 0, NONE);
    add_row(0, 65536, 0, 0, 65536, 0, 1, AXES);
    // coincident vertices: zero determinant
    add_row(7, 7, 7, 3, 3, 1, 0, NONE);
    add_row(7, 7, 7, 3, 3, 0, 0, NONE);
    add_row(7, 7, 7, 3, 3, 0, 1, DEGEN);
    // field extremes
    add_row(PMAX, PMAX, PMAX, UMAX, UMAX, 1, 0, NONE);
    add_row(PMIN, PMIN, PMIN, UMIN, UMIN, 0, 0, NONE);
    add_row(PMAX, PMIN, 0, UMIN, UMAX, 0, 0, NONE);
    // two leftovers dropped by a mesh start, then collinear UVs
    add_row(1, 2, 3, 4, 5, 1, 0, NONE);
    add_row(9, 8, 7, 6, 5, 0, 0, NONE);
    add_row(0, 0, 0, 0, 0, 1, 0, NONE);
    add_row(5, 6, 7, 1, 1, 0, 0, NONE);
    add_row(-5, 9, 2, 2, 2, 0, 1, DEGEN);
    // good UVs but equal positions: zero tangent
    add_row(100, -100, 50, 0, 0, 0, 0, NONE);
    add_row(100, -100, 50, 65536, 0, 0, 0, NONE);
    add_row(100, -100, 50, 0, 65536, 0, 1, DEGEN);
    // mirrored UVs: negative determinant
    add_row(0, 0, 0, 0, 0, 1, 0, NONE);
    add_row(65536, 0, 0, 65536, 0, 0, 0, NONE);
    add_row(0, 65536, 0, 0, -65536, 0, 1, MIRROR);
    // one leftover dropped, then extremes in the other order
    add_row(PMIN, PMAX, PMIN, UMAX, UMIN, 1, 0, NONE);
    add_row(PMAX, PMIN, PMAX, UMIN, UMAX, 1, 0, NONE);
    add_row(PMIN, PMAX, PMIN, UMAX, UMIN, 0, 0, NONE);
    add_row(0, PMIN, PMAX, 0, UMIN, 0, 0, NONE);

    tri_phase = 0;
    for (int i = 0; i < 6; i++) held_pos[i] = '0;
    for (int i = 0; i < 4; i++) held_uv[i] = '0;
    burst_left = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (table_rows[i]) send_vertex(table_rows[i]);

    // random meshes: mostly whole triangles, some broken ones
    tri_left = 0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if ($urandom_range(0, 19) == 0) r = rand_vertex(1'($urandom_range(0, 1)));
      else begin
        r = rand_vertex(tri_phase == 0 && $urandom_range(0, 3) == 0);
        // sometimes reuse a held vertex or UV to hit degenerate cases
        if (tri_phase != 0 && $urandom_range(0, 9) == 0) begin
          r.tu = held_uv[0]; r.tv = held_uv[1];
        end
        if (tri_phase != 0 && $urandom_range(0, 14) == 0) begin
          r.px = held_pos[0]; r.py = held_pos[1]; r.pz = held_pos[2];
        end
      end
      send_vertex(r);
    end
    in_valid_i = 1'b0;

    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("sent %0d vertices, checked %0d triangle results (%0d degenerate)",
             vertices_sent, frames_seen, degen_seen);
    $display("includes a %0d-cycle output hold with the input backed up", HOLD_CYCLES);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // receiver: random stalls, quiet stretches, one long hold
  initial begin
    int mode_left;
    int mode;
    mode_left = 0;
    mode = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!long_hold_done && frames_seen >= 30) begin
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        long_hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 300);
        mode = $urandom_range(0, 2);
      end
      mode_left--;
      case (mode)
        0: out_stall_i = 1'b0;
        1: out_stall_i = ($urandom_range(0, 3) == 0);
        default: out_stall_i = ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    frame_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_frames.size() == 0) begin
        $display("unexpected result at cycle %0d", cycles);
        errors++;
      end else begin
        e = expected_frames.pop_front();
        if (tangent_x_o != e.tx) report("tangent_x", tangent_x_o, e.tx);
        if (tangent_y_o != e.ty) report("tangent_y", tangent_y_o, e.ty);
        if (tangent_z_o != e.tz) report("tangent_z", tangent_z_o, e.tz);
        if (binormal_x_o != e.bx) report("binormal_x", binormal_x_o, e.bx);
        if (binormal_y_o != e.by) report("binormal_y", binormal_y_o, e.by);
        if (binormal_z_o != e.bz) report("binormal_z", binormal_z_o, e.bz);
        if (degenerate_o !== e.deg) report("degenerate", 16'(degenerate_o), 16'(e.deg));
        frames_seen++;
        if (e.deg) degen_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_frames.size());
      $display("status: fail");
      $finish;
    end
  end

endmodule
